[sv/stream_duplicate_detector_core_defines.svh]
// Assertion helpers for the duplicate detector; expect clk_i and rst_ni in scope.
`ifndef STREAM_DUPLICATE_DETECTOR_CORE_DEFINES_SVH
`define STREAM_DUPLICATE_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define SDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sdd_pkg.sv]
package sdd_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam logic [VALUE_W-1:0] HASH_MULT = 32'h9E37_79B1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } sdd_state_e;

  typedef struct packed {
    logic seen_before;
    logic any_duplicate;
    logic set_overflow;
    logic last_result;
  } sdd_result_t;

endpackage

[sv/sdd_in_if.sv]
interface sdd_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sdd_pkg::VALUE_W-1:0] value;
  logic                              last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

[sv/sdd_out_if.sv]
interface sdd_out_if;
  logic valid;
  logic ready;
  logic seen_before;
  logic any_duplicate;
  logic set_overflow;
  logic last_result;

  modport source (
    output valid, output seen_before, output any_duplicate, output set_overflow,
    output last_result, input ready
  );
  modport sink (
    input valid, input seen_before, input any_duplicate, input set_overflow,
    input last_result, output ready
  );
endinterface

[sv/sdd_front.sv]
module sdd_front #(
  parameter int unsigned SET_CAPACITY = 1024
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  sdd_in_if.sink                                       in_i,
  output logic                                         work_valid_o,
  input  logic                                         work_ready_i,
  output logic [sdd_pkg::VALUE_W-1:0]                  work_value_o,
  output logic                                         work_last_o,
  output logic [((SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1)-1:0] work_index_o
);

  localparam int unsigned IdxW  = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int unsigned CapW  = $clog2(SET_CAPACITY + 1);
  localparam int unsigned VW    = sdd_pkg::VALUE_W;
  localparam int unsigned ProdW = VW + CapW;

  logic            s1_valid_q, s1_valid_d;
  logic [VW-1:0]   s1_value_q;
  logic            s1_last_q;
  logic [VW-1:0]   s1_hash_q;
  logic            s2_valid_q, s2_valid_d;
  logic [VW-1:0]   s2_value_q;
  logic            s2_last_q;
  logic [IdxW-1:0] s2_index_q;
  logic            adv1, adv2;
  logic [VW-1:0]   hash;
  logic [ProdW-1:0] prod;

  assign adv2 = !s2_valid_q || work_ready_i;
  assign adv1 = !s1_valid_q || adv2;
  assign in_i.ready = adv1;

  assign hash = $unsigned(in_i.value) * sdd_pkg::HASH_MULT;
  assign prod = {{CapW{1'b0}}, s1_hash_q} * ProdW'(SET_CAPACITY);

  always_comb begin
    s1_valid_d = s1_valid_q;
    s2_valid_d = s2_valid_q;
    if (adv2) begin
      s2_valid_d = s1_valid_q;
    end
    if (adv1) begin
      s1_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_i.valid) begin
      s1_value_q <= $unsigned(in_i.value);
      s1_last_q  <= in_i.last_item;
      s1_hash_q  <= hash;
    end
    if (adv2 && s1_valid_q) begin
      s2_value_q <= s1_value_q;
      s2_last_q  <= s1_last_q;
      s2_index_q <= prod[VW +: IdxW];
    end
  end

  assign work_valid_o = s2_valid_q;
  assign work_value_o = s2_value_q;
  assign work_last_o  = s2_last_q;
  assign work_index_o = s2_index_q;

endmodule

[sv/sdd_fifo.sv]
module sdd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/sdd_back.sv]
module sdd_back #(
  parameter int unsigned SET_CAPACITY = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  logic [sdd_pkg::VALUE_W-1:0] item_value_i,
  input  logic                        item_last_i,
  input  logic [((SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1)-1:0] item_index_i,
  sdd_out_if.source                   out_o
);

  localparam int unsigned IdxW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int unsigned VW   = sdd_pkg::VALUE_W;
  localparam int unsigned TagW = sdd_pkg::EPOCH_W;
  localparam int unsigned EntW = TagW + VW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SET_CAPACITY - 1);
  localparam logic [TagW-1:0] TagMax  = {TagW{1'b1}};

  sdd_pkg::sdd_state_e  state_q, state_d;
  logic [IdxW-1:0]      clr_idx_q, clr_idx_d;
  logic [TagW-1:0]      epoch_q, epoch_d;
  logic                 dup_q, dup_d;
  logic                 ovf_q, ovf_d;
  logic [VW-1:0]        val_q, val_d;
  logic                 last_q, last_d;
  logic [IdxW-1:0]      addr_q, addr_d;
  logic [IdxW-1:0]      probes_q, probes_d;
  sdd_pkg::sdd_result_t res_q, res_d;
  logic                 res_valid_q, res_valid_d;

  logic [EntW-1:0] mem_q [SET_CAPACITY];
  logic [EntW-1:0] rd_data_q;
  logic [IdxW-1:0] rd_addr, wr_addr, next_addr;
  logic [EntW-1:0] wr_data;
  logic            mem_we;
  logic            out_free, live, match, wrapped, dup_nxt, ovf_nxt;

  assign out_free  = !res_valid_q || out_o.ready;
  assign live      = rd_data_q[EntW-1:VW] == epoch_q;
  assign match     = live && (rd_data_q[VW-1:0] == val_q);
  assign wrapped   = probes_q == LastIdx;
  assign next_addr = (addr_q == LastIdx) ? '0 : addr_q + 1'b1;
  assign dup_nxt   = dup_q || match;
  assign ovf_nxt   = ovf_q || (!match && live);

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    epoch_d      = epoch_q;
    dup_d        = dup_q;
    ovf_d        = ovf_q;
    val_d        = val_q;
    last_d       = last_q;
    addr_d       = addr_q;
    probes_d     = probes_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q && !out_o.ready;
    rd_addr      = addr_q;
    wr_addr      = addr_q;
    wr_data      = {epoch_q, val_q};
    mem_we       = 1'b0;
    item_ready_o = 1'b0;
    case (state_q)
      sdd_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        wr_addr   = clr_idx_q;
        wr_data   = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == LastIdx) begin
          clr_idx_d = '0;
          epoch_d   = TagW'(1);
          state_d   = sdd_pkg::ST_IDLE;
        end
      end
      sdd_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          val_d    = item_value_i;
          last_d   = item_last_i;
          addr_d   = item_index_i;
          probes_d = '0;
          rd_addr  = item_index_i;
          state_d  = sdd_pkg::ST_LOOK;
        end
      end
      sdd_pkg::ST_LOOK: begin
        if (match || !live || wrapped) begin
          if (out_free) begin
            res_d.seen_before   = match;
            res_d.any_duplicate = dup_nxt;
            res_d.set_overflow  = ovf_nxt;
            res_d.last_result   = last_q;
            res_valid_d         = 1'b1;
            mem_we              = !match && !live;
            state_d             = sdd_pkg::ST_IDLE;
            if (last_q) begin
              dup_d = 1'b0;
              ovf_d = 1'b0;
              if (epoch_q == TagMax) begin
                state_d = sdd_pkg::ST_CLEAR;
              end else begin
                epoch_d = epoch_q + 1'b1;
              end
            end else begin
              dup_d = dup_nxt;
              ovf_d = ovf_nxt;
            end
          end
        end else begin
          addr_d   = next_addr;
          probes_d = probes_q + 1'b1;
          rd_addr  = next_addr;
        end
      end
      default: begin
        state_d = sdd_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdd_pkg::ST_CLEAR;
      clr_idx_q   <= '0;
      epoch_q     <= '0;
      dup_q       <= 1'b0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      epoch_q     <= epoch_d;
      dup_q       <= dup_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    last_q   <= last_d;
    addr_q   <= addr_d;
    probes_q <= probes_d;
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.seen_before   = res_q.seen_before;
  assign out_o.any_duplicate = res_q.any_duplicate;
  assign out_o.set_overflow  = res_q.set_overflow;
  assign out_o.last_result   = res_q.last_result;

endmodule

[sv/stream_duplicate_detector_core.sv]
// Duplicate detector over a stream of arrays: each request carries one 32-bit value and an
// end-of-array flag, and yields one result telling whether the value already occurred in the
// current array, plus sticky duplicate and set-full flags that clear after the last element.
// Values live in a hashed set of SET_CAPACITY entries in a single-port-read memory with linear
// probing, one probe per cycle; each entry carries an epoch tag so an array end clears the set
// at once. A front stage hashes values (pipelined) into a four-entry queue; the probe engine
// then takes one value at a time, probing from its hashed slot until it finds the value, a
// free entry, or has probed every entry. After reset, and after every 255th array end, a
// clearing pass over all SET_CAPACITY entries runs in which the probe engine takes no values
// while the front keeps filling its queue.
module stream_duplicate_detector_core #(
  parameter int unsigned SET_CAPACITY = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdd_in_if.sink    in_i,
  sdd_out_if.source out_o
);

  localparam int unsigned IdxW  = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int unsigned VW    = sdd_pkg::VALUE_W;
  localparam int unsigned WorkW = IdxW + 1 + VW;

  logic            fr_valid, fr_ready;
  logic [VW-1:0]   fr_value;
  logic            fr_last;
  logic [IdxW-1:0] fr_index;
  logic            bk_valid, bk_ready;
  logic [WorkW-1:0] bk_data;

  sdd_front #(
    .SET_CAPACITY(SET_CAPACITY)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .work_valid_o (fr_valid),
    .work_ready_i (fr_ready),
    .work_value_o (fr_value),
    .work_last_o  (fr_last),
    .work_index_o (fr_index)
  );

  sdd_fifo #(
    .Width(WorkW),
    .Depth(sdd_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  ({fr_index, fr_last, fr_value}),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_data)
  );

  sdd_back #(
    .SET_CAPACITY(SET_CAPACITY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_value_i (bk_data[VW-1:0]),
    .item_last_i  (bk_data[VW]),
    .item_index_i (bk_data[WorkW-1:VW+1]),
    .out_o        (out_o)
  );

endmodule

[sv/sdd_checker.sv]
`include "stream_duplicate_detector_core_defines.svh"

module sdd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic seen_before_i,
  input logic any_duplicate_i
);

  `SDD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  `SDD_ASSERT_NOW(a_dup_sticky, out_valid_i && seen_before_i, any_duplicate_i,
    "duplicate without sticky flag")

  `SDD_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i,
    $stable(seen_before_i) && $stable(any_duplicate_i), "result changed while held")

endmodule

bind stream_duplicate_detector_core sdd_checker u_sdd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .seen_before_i   (out_o.seen_before),
  .any_duplicate_i (out_o.any_duplicate)
);
